// ----- hdl/pts_pkg.sv -----
// package for the pseudocode token splitter
// request types, byte classes, lexer mode codes and queue sizing; no dependencies
package pts_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  localparam logic [3:0] M_NONE    = 4'd0;
  localparam logic [3:0] M_NUMBER  = 4'd1;
  localparam logic [3:0] M_WORD    = 4'd2;
  localparam logic [3:0] M_STRING  = 4'd3;
  localparam logic [3:0] M_CHAR    = 4'd4;
  localparam logic [3:0] M_LESS    = 4'd5;
  localparam logic [3:0] M_EQUAL   = 4'd6;
  localparam logic [3:0] M_GREATER = 4'd7;
  localparam logic [3:0] M_DOT     = 4'd8;
  localparam logic [3:0] M_SLASH   = 4'd9;
  localparam logic [3:0] M_COMMENT = 4'd10;

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       first_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       starts_token;
    logic [3:0] mode_after;
  } out_item_t;

  typedef struct packed {
    logic is_digit;
    logic is_letter;
    logic is_under;
    logic is_apos;
    logic is_dquote;
    logic is_lt;
    logic is_eq;
    logic is_gt;
    logic is_dot;
    logic is_slash;
    logic is_star;
    logic is_minus;
    logic is_graph;
  } cls_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       first_of_text;
    cls_t       cls;
  } q_item_t;

endpackage

// ----- hdl/pseudocode_token_splitter.sv -----
// pseudocode token splitter, top level
// wires pts_front, pts_queue and pts_lexer; depends on pts_pkg
//
// One text byte is taken per request and up to one result follows for it, so the block
// runs at one byte per clock while out_stall stays low. A byte passes the classifier,
// waits in a four-entry queue and reaches the lexer, whose mode and previous-byte
// registers update once per byte; that loop sets the rate. A taken byte is written
// into a queue entry, and its result into the result register when the lexer pops it.
// Dropped bytes (blanks, control bytes other than 0x7F and high bytes outside a token,
// and bytes that end a number, word or operator without starting another token) give
// no result. in_stall rises only when the queue is full, which takes a stall on the
// output side.
module pseudocode_token_splitter import pts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  in_item_t  in_data,
  output logic      in_stall,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_stall
);

  logic    q_full;
  logic    push;
  q_item_t push_item;
  logic    pop;
  logic    q_valid;
  q_item_t q_item;

  pts_front u_front (
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  pts_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  pts_lexer u_lexer (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

endmodule

// ----- hdl/pts_front.sv -----
// front end: takes input requests, classifies the byte and pushes it to the queue
// depends on pts_pkg
module pts_front import pts_pkg::*; (
  input  logic     in_valid,
  input  in_item_t in_data,
  output logic     in_stall,
  input  logic     q_full,
  output logic     push,
  output q_item_t  push_item
);

  logic [7:0] b;
  cls_t       c;

  assign b = in_data.text_byte;

  always_comb begin
    c.is_digit  = (b >= 8'h30) && (b <= 8'h39);
    c.is_letter = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
    c.is_under  = (b == CH_UNDER);
    c.is_apos   = (b == CH_APOS);
    c.is_dquote = (b == CH_DQUOTE);
    c.is_lt     = (b == CH_LT);
    c.is_eq     = (b == CH_EQ);
    c.is_gt     = (b == CH_GT);
    c.is_dot    = (b == CH_DOT);
    c.is_slash  = (b == CH_SLASH);
    c.is_star   = (b == CH_STAR);
    c.is_minus  = (b == CH_MINUS);
    // unsigned compare; high bytes are kept out by bit 7 and rank apart from blank
    c.is_graph  = !b[7] && (b > CH_SPACE);
  end

  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;
  assign push_item = '{text_byte: b, first_of_text: in_data.first_of_text, cls: c};

endmodule

// ----- hdl/pts_queue.sv -----
// short queue between the classifying front end and the lexer back end
// depends on pts_pkg
module pts_queue import pts_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t push_item,
  output logic    full,
  input  logic    pop,
  output logic    q_valid,
  output q_item_t q_item
);

  q_item_t        mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] count_r, count_nxt;

  assign full    = (count_r == QCW'(QDEPTH));
  assign q_valid = (count_r != '0);
  assign q_item  = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCW'(QDEPTH))
    else $error("queue count beyond depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + 1'b1)
    else $error("queue count did not grow on push");

endmodule

// ----- hdl/pts_lexer.sv -----
// back end: lexer mode update per queued byte and the output register
// depends on pts_pkg
module pts_lexer import pts_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  q_item_t   q_item,
  output logic      pop,
  output logic      out_valid,
  output out_item_t out_data,
  input  logic      out_stall
);

  logic [3:0] mode_r, mode_nxt;
  logic [7:0] prev_r, prev_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_item_t  out_data_r, out_data_nxt;

  logic [3:0] m0, m1, m2;
  logic [7:0] pv;
  logic       keep, start;
  cls_t       c;

  assign c   = q_item.cls;
  assign pop = q_valid && (!out_valid_r || !out_stall);

  always_comb begin
    m0    = q_item.first_of_text ? M_NONE : mode_r;
    pv    = q_item.first_of_text ? 8'h00 : prev_r;
    keep  = (m0 != M_NONE);
    start = 1'b0;

    // closing quote or closing star-slash
    m1 = m0;
    if ((m0 == M_STRING) && c.is_dquote) begin
      if (pv != CH_BSLASH) m1 = M_NONE;
    end else if ((m0 == M_CHAR) && c.is_apos) begin
      if (pv != CH_BSLASH) m1 = M_NONE;
    end else if ((m0 == M_COMMENT) && c.is_slash) begin
      if (pv == CH_STAR) m1 = M_NONE;
    end

    m2 = m1;
    case (m1)
      M_NUMBER: begin
        if (!c.is_digit && !c.is_dot) begin
          m2   = M_NONE;
          keep = 1'b0;
        end
      end
      M_WORD: begin
        if (!c.is_digit && !c.is_letter && !c.is_under && !c.is_apos) begin
          m2   = M_NONE;
          keep = 1'b0;
        end
      end
      M_LESS, M_EQUAL, M_GREATER: begin
        if (!c.is_eq && ((m1 != M_LESS) || (!c.is_minus && !c.is_gt))) begin
          keep = 1'b0;
        end
        m2 = M_NONE;
      end
      M_DOT: begin
        if (c.is_digit) begin
          m2 = M_NUMBER;
        end else begin
          m2   = M_NONE;
          keep = 1'b0;
        end
      end
      M_SLASH: begin
        if (c.is_slash || c.is_star) begin
          m2 = M_COMMENT;
        end else begin
          m2   = M_NONE;
          keep = 1'b0;
        end
      end
      default: begin
      end
    endcase

    // new token
    if ((m2 == M_NONE) && !keep && c.is_graph) begin
      start = 1'b1;
      if (c.is_digit)                   m2 = M_NUMBER;
      else if (c.is_letter || c.is_under) m2 = M_WORD;
      else if (c.is_dquote)             m2 = M_STRING;
      else if (c.is_apos)               m2 = M_CHAR;
      else if (c.is_lt)                 m2 = M_LESS;
      else if (c.is_eq)                 m2 = M_EQUAL;
      else if (c.is_gt)                 m2 = M_GREATER;
      else if (c.is_dot)                m2 = M_DOT;
      else if (c.is_slash)              m2 = M_SLASH;
    end
  end

  always_comb begin
    mode_nxt      = mode_r;
    prev_nxt      = prev_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    if (pop) begin
      mode_nxt      = m2;
      prev_nxt      = q_item.text_byte;
      out_valid_nxt = keep || start;
      out_data_nxt  = '{out_byte: q_item.text_byte, starts_token: start, mode_after: m2};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= M_NONE;
      prev_r      <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r <= M_COMMENT)
    else $error("lexer mode out of range");

  a_start_printable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.starts_token) |->
      (!out_data_r.out_byte[7] && (out_data_r.out_byte > CH_SPACE)))
    else $error("token started on blank or high byte");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && !pop) |=> !out_valid_r)
    else $error("taken result still shown");

  a_mode_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && (keep || start)) |=> (out_data_r.mode_after == mode_r))
    else $error("result mode differs from lexer mode");

endmodule
